// ===== rtl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// No dependencies; imported by ple_cell and positional_list_engine_core.
`default_nettype none

package ple_pkg;

  // Width of a slot index carried to the cells; covers capacities up to 64.
  localparam int SLOT_W = 6;
  localparam int DATA_W = 32;

  // Action codes on the input item
  localparam logic [2:0] ACT_INS_HEAD = 3'd0;
  localparam logic [2:0] ACT_INS_TAIL = 3'd1;
  localparam logic [2:0] ACT_INS_POS  = 3'd2;
  localparam logic [2:0] ACT_DEL_HEAD = 3'd3;
  localparam logic [2:0] ACT_DEL_TAIL = 3'd4;
  localparam logic [2:0] ACT_DEL_POS  = 3'd5;
  localparam logic [2:0] ACT_DUMP     = 3'd6;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,  // keep value
    CM_INS  = 2'd1,  // open a gap at slot, load value there
    CM_DEL  = 2'd2,  // close the gap at slot
    CM_ROT  = 2'd3   // rotate towards head, head value wraps to slot
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] load_val;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: control, count and the cell chain.
// Depends on ple_pkg and ple_cell.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one item: action, value,
//    position. Output channel (out_valid / out_stall) carries results:
//    status, count, item_value, last. An item moves when valid is high and
//    stall is low at a rising edge.
//  - Inserts and deletes: the item is accepted, the cells at and beyond the
//    slot shift or load at that edge and the single result sits in the output
//    register from the next cycle. One such item per cycle is sustained unless stalled.
//  - A dump of N elements enters a dump state, then gives N results, one per
//    cycle unless stalled, head first, last on the final one. The chain rotates
//    one cell per result, so the list ends in order. No new item is taken meanwhile.
//  - An empty dump, a full insert, an empty delete or a bad position give
//    one result with the matching status; the list stays as it was.
//  - Action 7 is accepted and dropped with no result.
//  - When the receiver stalls, the output register holds its result and the
//    input stalls until it is free or being taken in the same cycle.
//  - Reset (rst, synchronous) empties the list and clears the output valid;
//    the cell values themselves are not cleared.
`default_nettype none

module positional_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire         [2:0]  action,
  input  wire  signed [31:0] value,
  input  wire         [4:0]  position,
  output logic               out_valid,
  input  wire                out_stall,
  output logic        [1:0]  status,
  output logic        [4:0]  count,
  output logic signed [31:0] item_value,
  output logic               last
);
  import ple_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);       // element count width
  localparam int IW    = $clog2(CAPACITY);           // cell index width
  localparam int CMP_W = ((CW > 5) ? CW : 5) + 1;     // room for count+1 vs position

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;    // elements held
  logic [CW-1:0] rem, rem_next;    // dump results still to give

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  cell_cmd_t                cmd;

  logic accept, out_free, out_load;
  logic [1:0]               sts_n;
  logic signed [DATA_W-1:0] val_n;
  logic                     last_n;

  logic [CMP_W-1:0] pos_w, cnt_w, ins_slot_w, del_slot_w, tail_slot_w;
  logic [IW-1:0]    del_idx;
  logic             full, empty, ins_ok, del_ok;
  logic [CW+4:0]    cnt_ext;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_RUN) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign pos_w = {{(CMP_W-5){1'b0}}, position};
  assign cnt_w = {{(CMP_W-CW){1'b0}}, cnt};
  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);

  // position is 1-based: insert may land one beyond the tail, delete may not
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);

  assign tail_slot_w = cnt_w - CMP_W'(1);

  always_comb begin
    case (action)
      ACT_INS_TAIL: ins_slot_w = cnt_w;
      ACT_INS_POS:  ins_slot_w = pos_w - CMP_W'(1);
      default:      ins_slot_w = '0;
    endcase
    case (action)
      ACT_DEL_TAIL: del_slot_w = tail_slot_w;
      ACT_DEL_POS:  del_slot_w = pos_w - CMP_W'(1);
      default:      del_slot_w = '0;
    endcase
  end

  assign del_idx = del_slot_w[IW-1:0];

  // Control: decide the cell command and the result of this cycle
  always_comb begin
    cmd        = '{mode: CM_HOLD, slot: '0, load_val: '0};
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    out_load   = 1'b0;
    sts_n      = STS_OK;
    val_n      = '0;
    last_n     = 1'b1;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          unique case (action) inside
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
              out_load = 1'b1;
              if (full) begin
                sts_n = STS_FULL;
              end else if ((action == ACT_INS_POS) && !ins_ok) begin
                sts_n = STS_RANGE;
              end else begin
                cmd.mode     = CM_INS;
                cmd.slot     = ins_slot_w[SLOT_W-1:0];
                cmd.load_val = value;
                cnt_next     = cnt + CW'(1);
              end
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS: begin
              out_load = 1'b1;
              if (empty) begin
                sts_n = STS_EMPTY;
              end else if ((action == ACT_DEL_POS) && !del_ok) begin
                sts_n = STS_RANGE;
              end else begin
                cmd.mode = CM_DEL;
                cmd.slot = del_slot_w[SLOT_W-1:0];
                val_n    = cell_q[del_idx];
                cnt_next = cnt - CW'(1);
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                out_load = 1'b1;
                sts_n    = STS_EMPTY;
              end else begin
                state_next = ST_DUMP;
                rem_next   = cnt;
              end
            end
            default: ;  // unused action: dropped
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          // head goes out and wraps round to the tail slot
          out_load     = 1'b1;
          val_n        = cell_q[0];
          last_n       = (rem == CW'(1));
          cmd.mode     = CM_ROT;
          cmd.slot     = tail_slot_w[SLOT_W-1:0];
          cmd.load_val = cell_q[0];
          rem_next     = rem - CW'(1);
          if (rem == CW'(1)) state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  assign cnt_ext = {5'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      cnt       <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= sts_n;
      count      <= cnt_ext[4:0];
      item_value <= val_n;
      last       <= last_n;
    end
  end

  // The chain: cell i sees its neighbours i-1 and i+1
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = cell_q[i];
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_q  (left_d),
      .right_q (right_d),
      .q       (cell_q[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// One storage cell of the list chain.
// Depends on ple_pkg for the broadcast command type.
`default_nettype none

module ple_cell #(
  parameter int INDEX = 0
) (
  input  wire                            clk,
  input  wire  ple_pkg::cell_cmd_t       cmd,
  input  wire  signed [ple_pkg::DATA_W-1:0] left_q,
  input  wire  signed [ple_pkg::DATA_W-1:0] right_q,
  output logic signed [ple_pkg::DATA_W-1:0] q
);
  import ple_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (cmd.mode)
      CM_INS: begin
        if (MY_SLOT == cmd.slot) q_next = cmd.load_val;
        else if (MY_SLOT > cmd.slot) q_next = left_q;
      end
      CM_DEL: begin
        if (MY_SLOT >= cmd.slot) q_next = right_q;
      end
      CM_ROT: begin
        if (MY_SLOT == cmd.slot) q_next = cmd.load_val;
        else if (MY_SLOT < cmd.slot) q_next = right_q;
      end
      default: q_next = q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ===== tb/positional_list_engine_core_test.sv =====
// Self-checking bench for positional_list_engine_core: directed table, then random list traffic.
// A shadow list predicts every result. Needs ple_pkg and the engine RTL, nothing else.
`timescale 1ns / 100ps

module positional_list_engine_core_test;
  import ple_pkg::*;

  localparam int          CAPACITY       = 16;
  localparam int          RANDOM_ITEMS   = 165;
  localparam int          HOLD_CYCLES    = 80;   // long receiver hold-off
  localparam int          DRAIN_CYCLES   = CAPACITY + 8;
  localparam logic [2:0]  ACT_UNUSED     = 3'd7; // accepted, dropped, no result

  // One result as seen on the output channel
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] item_value;
    logic               last;
  } result_t;

  // One row of the directed table; rows with 'typed' carry their result written out
  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] val;
    logic [4:0]         pos;
    int                 reps;
    bit                 typed;
    result_t            want;
  } vector_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         action;
  logic signed [31:0] value;
  logic [4:0]         position;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] item_value;
  logic               last;

  logic signed [31:0] list_image[$];        // shadow of the list, head first
  result_t            step_results[$];      // results of the item just accepted
  result_t            awaited_results[$];   // every result not yet seen, oldest first
  vector_t            directed_rows[$];
  result_t            oldest;

  int  failures      = 0;
  int  items_sent    = 0;
  int  dumps_sent    = 0;
  int  results_seen  = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  bit  quiet_tail    = 1'b0;  // no idling on either side near the end
  bit  sender_gaps_off = 1'b0;
  bit  hold_request  = 1'b0;

  positional_list_engine_core #(.CAPACITY(CAPACITY)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .count      (count),
    .item_value (item_value),
    .last       (last)
  );

  always #4 clk = ~clk;

  // Hard stop, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one action to the shadow list and leaves its results
  // in step_results. A refused request leaves the list as it was.
  // ---------------------------------------------------------------------------
  function automatic void predict_list_action(input logic [2:0] act,
                                              input logic signed [31:0] val,
                                              input logic [4:0] pos);
    int                 n;
    int                 slot;
    logic signed [31:0] taken;
    n = list_image.size();
    step_results.delete();
    case (act)
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
        // full check wins over a bad position
        if (n >= CAPACITY) begin
          step_results.push_back('{STS_FULL, 5'(n), 32'sd0, 1'b1});
        end else if (act == ACT_INS_POS && (pos < 1 || pos > n + 1)) begin
          step_results.push_back('{STS_RANGE, 5'(n), 32'sd0, 1'b1});
        end else begin
          slot = (act == ACT_INS_HEAD) ? 0 : (act == ACT_INS_TAIL) ? n : pos - 1;
          list_image.insert(slot, val);
          step_results.push_back('{STS_OK, 5'(n + 1), 32'sd0, 1'b1});
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS: begin
        // empty list wins over any position
        if (n == 0) begin
          step_results.push_back('{STS_EMPTY, 5'd0, 32'sd0, 1'b1});
        end else if (act == ACT_DEL_POS && (pos < 1 || pos > n)) begin
          step_results.push_back('{STS_RANGE, 5'(n), 32'sd0, 1'b1});
        end else begin
          slot  = (act == ACT_DEL_HEAD) ? 0 : (act == ACT_DEL_TAIL) ? n - 1 : pos - 1;
          taken = list_image[slot];
          list_image.delete(slot);
          step_results.push_back('{STS_OK, 5'(n - 1), taken, 1'b1});
        end
      end
      ACT_DUMP: begin
        if (n == 0) begin
          step_results.push_back('{STS_EMPTY, 5'd0, 32'sd0, 1'b1});
        end else begin
          for (int i = 0; i < n; i++)
            step_results.push_back('{STS_OK, 5'(n), list_image[i], 1'(i == n - 1)});
        end
      end
      default: ; // unused code: no result, list untouched
    endcase
  endfunction

  task automatic add_row(input logic [2:0] act, input logic signed [31:0] val,
                         input logic [4:0] pos, input int reps, input bit typed,
                         input logic [1:0] st, input int cnt, input logic signed [31:0] iv);
    vector_t r;
    r.act   = act;
    r.val   = val;
    r.pos   = pos;
    r.reps  = reps;
    r.typed = typed;
    r.want  = '{st, 5'(cnt), iv, 1'b1};
    directed_rows.push_back(r);
  endtask

  // Offers one item, holds it until taken, then books its results.
  // in_valid is only lowered when a gap follows, so a back-to-back item
  // never sees valid dropped and raised in the same step.
  task automatic offer_item(input logic [2:0] act, input logic signed [31:0] val,
                            input logic [4:0] pos, input bit typed, input result_t want);
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (in_stall);
    predict_list_action(act, val, pos);
    if (typed)
      awaited_results.push_back(want);
    else
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    if (act != ACT_UNUSED) items_sent++;
    if (act == ACT_DUMP) dumps_sent++;
    if (!quiet_tail && !sender_gaps_off && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every taken result against the oldest one awaited.
  // ---------------------------------------------------------------------------
  task automatic field_check(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      status_seen[status]++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none awaited, expected nothing, got status %0d count %0d value %0d",
                 $time, status, count, item_value);
        failures++;
      end else begin
        oldest = awaited_results.pop_front();
        field_check("status", oldest.status, status);
        field_check("count", oldest.count, count);
        field_check("item_value", oldest.item_value, item_value);
        field_check("last", oldest.last, last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    vector_t            row;
    int                 random_sent;
    int                 n;
    int                 pick;
    bit                 filling;
    logic [2:0]         act;
    logic signed [31:0] val;
    logic [4:0]         pos;

    in_valid = 1'b0;
    action   = ACT_INS_HEAD;
    value    = 32'sd0;
    position = 5'd0;
    rst      = 1'b1;

    // Directed table. Typed rows: act, val, pos, reps, 1, status, count, item_value.
    add_row(ACT_DUMP,     0,             0,  1, 1, STS_EMPTY, 0, 0);  // dump of empty list
    add_row(ACT_DEL_HEAD, 0,             0,  1, 1, STS_EMPTY, 0, 0);  // deletes on empty list
    add_row(ACT_DEL_TAIL, 0,             0,  1, 1, STS_EMPTY, 0, 0);
    add_row(ACT_DEL_POS,  0,             31, 1, 1, STS_EMPTY, 0, 0);  // empty beats bad position
    add_row(ACT_INS_POS,  5,             0,  1, 1, STS_RANGE, 0, 0);  // position zero
    add_row(ACT_INS_POS,  5,             2,  1, 1, STS_RANGE, 0, 0);  // beyond count+1
    add_row(ACT_INS_HEAD, 32'h7FFF_FFFF, 0,  1, 1, STS_OK,    1, 0);
    add_row(ACT_INS_TAIL, 32'h8000_0000, 31, 1, 1, STS_OK,    2, 0);
    add_row(ACT_INS_POS,  -1,            2,  1, 1, STS_OK,    3, 0);
    add_row(ACT_INS_POS,  7,             31, 1, 1, STS_RANGE, 3, 0);
    add_row(ACT_UNUSED,   -1,            31, 1, 0, STS_OK,    0, 0);  // dropped silently
    add_row(ACT_DUMP,     0,             0,  1, 0, STS_OK,    0, 0);
    add_row(ACT_DEL_POS,  0,             0,  1, 1, STS_RANGE, 3, 0);
    add_row(ACT_DEL_POS,  0,             4,  1, 1, STS_RANGE, 3, 0);  // above count
    add_row(ACT_DEL_POS,  0,             2,  1, 1, STS_OK,    2, -1);
    add_row(ACT_DEL_HEAD, 0,             0,  1, 1, STS_OK,    1, 32'h7FFF_FFFF);
    add_row(ACT_DEL_TAIL, 0,             0,  1, 1, STS_OK,    0, 32'h8000_0000);
    add_row(ACT_INS_POS,  0,             1,  1, 1, STS_OK,    1, 0);
    add_row(ACT_INS_TAIL, 32'h5555_5555, 0, 15, 0, STS_OK,    0, 0);  // fill to capacity
    add_row(ACT_INS_HEAD, 1,             0,  1, 1, STS_FULL, 16, 0);
    add_row(ACT_INS_POS,  1,             1,  1, 1, STS_FULL, 16, 0);
    add_row(ACT_INS_POS,  1,             0,  1, 1, STS_FULL, 16, 0);  // full beats bad position
    add_row(ACT_INS_TAIL, 1,             0,  1, 1, STS_FULL, 16, 0);
    add_row(ACT_DUMP,     0,             0,  1, 0, STS_OK,    0, 0);  // longest dump
    add_row(ACT_DEL_POS,  0,             16, 1, 0, STS_OK,    0, 0);
    add_row(ACT_DEL_POS,  0,             16, 1, 1, STS_RANGE, 15, 0);
    add_row(ACT_DEL_POS,  0,             1,  1, 1, STS_OK,   14, 0);
    add_row(ACT_INS_POS,  9,             16, 1, 1, STS_RANGE, 14, 0);
    add_row(ACT_INS_POS,  9,             15, 1, 0, STS_OK,    0, 0);  // exactly count+1
    add_row(ACT_DUMP,     0,             0,  1, 0, STS_OK,    0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.reps; k++)
        offer_item(row.act, row.val, row.pos, row.typed, row.want);
    end

    // Random part: swing the list between empty and full with well-formed
    // requests, salted with dumps, noise and the unused code.
    random_sent = 0;
    filling     = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      n = list_image.size();
      if (filling && n == CAPACITY && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (!filling && n == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

      quiet_tail = (random_sent >= RANDOM_ITEMS - 40);

      // long receiver hold-off with the sender pushing back-to-back
      if (random_sent == 60) begin
        hold_request    = 1'b1;
        sender_gaps_off = 1'b1;
      end
      if (random_sent == 95) sender_gaps_off = 1'b0;

      // sender stops until everything awaited has arrived
      if (random_sent == 120) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
      end

      case ($urandom_range(0, 9))
        0:       val = 32'h7FFF_FFFF;
        1:       val = 32'h8000_0000;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        act = ACT_UNUSED;
        pos = 5'($urandom_range(0, 31));
      end else if (pick < 11) begin
        act = ACT_DUMP;
        pos = 5'($urandom_range(0, 31));
      end else if (pick < 19) begin
        act = 3'($urandom_range(0, 6));             // noise: any action, any position
        pos = 5'($urandom_range(0, 31));
      end else if ((filling && pick < 85) || (!filling && pick >= 85)) begin
        act = 3'($urandom_range(ACT_INS_HEAD, ACT_INS_POS));
        pos = 5'($urandom_range(1, n + 1));
      end else begin
        act = 3'($urandom_range(ACT_DEL_HEAD, ACT_DEL_POS));
        pos = (n == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, n));
      end

      offer_item(act, val, pos, 1'b0, '0);
      if (act != ACT_UNUSED) random_sent++;
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // a dump may still be running; anything extra shows up as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items including %0d dumps, %0d results checked",
             items_sent, dumps_sent, results_seen);
    $display("Statuses seen: ok %0d, empty %0d, full %0d, out of range %0d",
             status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_FULL],
             status_seen[STS_RANGE]);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
